/* hw/rtl/hrf_pkg.sv */
// ============================================================================
// hrf_pkg - shared constants, types and helpers of the haversine radius filter
// Fixed-point formats, angle constants, arctangent table, pipeline stage map.
// ============================================================================
package hrf_pkg;

  // Fixed point: radians and unit values are signed Q2.FRAC
  localparam int FRAC          = 30;
  localparam int CORDIC_STAGES = 24;
  localparam int TAYLOR_TERMS  = 12;

  localparam logic [30:0] ONE = 31'd1 << FRAC;

  // Angles in half-micro-degrees
  localparam int FULL_TURN_U    = 720000000;
  localparam int HALF_TURN_U    = 360000000;
  localparam int QUARTER_TURN_U = 180000000;

  // round(pi * 2^62 / 360000000): half-micro-degrees to radians in Q62
  localparam logic [35:0] RAD_PER_U  = 36'd40244552546;
  localparam logic [30:0] HALF_PI    = 31'd1686629713;
  localparam logic [23:0] DIAMETER_M = 24'd12742000;
  localparam logic [24:0] DIST_MAX   = 25'd20015087;

  // Configuration register indexes
  localparam logic [1:0] CFG_CENTER_LAT = 2'd0;
  localparam logic [1:0] CFG_CENTER_LON = 2'd1;
  localparam logic [1:0] CFG_RADIUS     = 2'd2;

  // Stage map: index of the register stage that holds each result
  localparam int SIN_LAT = 5 + 3 * TAYLOR_TERMS + 2;
  localparam int T_SIN   = SIN_LAT;
  localparam int T_H     = T_SIN + 4;
  localparam int T_SQ    = T_H + FRAC + 1;
  localparam int T_CO    = T_SQ + CORDIC_STAGES;
  localparam int T_OUT   = T_CO + 2;

  typedef logic signed [30:0] angle_t;   // half-micro-degrees
  typedef logic signed [31:0] unit_t;    // signed Q30 sine / cosine

  // atan(2^-i) in Q30
  function automatic logic [30:0] atan_q(input int i);
    logic [30:0] v;
    case (i)
      0:       v = 31'd843314857;
      1:       v = 31'd497837829;
      2:       v = 31'd263043837;
      3:       v = 31'd133525159;
      4:       v = 31'd67021687;
      5:       v = 31'd33543516;
      6:       v = 31'd16775851;
      7:       v = 31'd8388437;
      8:       v = 31'd4194283;
      9:       v = 31'd2097149;
      10:      v = 31'd1048576;
      default: v = (i <= FRAC) ? (31'd1 << (FRAC - i)) : 31'd1;
    endcase
    return v;
  endfunction

  // magnitude of a unit value, at most ONE
  function automatic logic [30:0] mag(input unit_t v);
    unit_t n;
    n = -v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

  // round a Q60 product back to Q30, half away from zero on a magnitude
  function automatic logic [31:0] rnd_q(input logic [61:0] p);
    logic [62:0] s;
    s = {1'b0, p} + (63'd1 << (FRAC - 1));
    return s[61:30];
  endfunction

endpackage

/* hw/rtl/haversine_radius_filter_core.sv */
// ============================================================================
// haversine_radius_filter_core - great-circle distance and radius test
// Streams geographic points and returns their distance from a set centre.
// ============================================================================
//
// Usage:
//   Input stream (s_*): one request per point; s_tdata holds point_id,
//   latitude and longitude in micro-degrees, s_tlast marks the last point
//   of a candidate set.
//   Output stream (m_*): one request per point, in order; m_tdata holds the
//   id and the distance in metres (saturated at half the circumference),
//   m_tuser says the distance is within the radius, m_tlast copies s_tlast.
//   Configuration: write centre latitude, centre longitude and radius
//   through cfg_wr_en / cfg_addr / cfg_wdata while no point is in flight.
// Timing:
//   One point enters every cycle while the output is not stalled. The
//   depth is set by the four parallel sine pipelines (three stages per
//   Taylor level), the two digit-by-digit square roots (one result bit per
//   stage) and the CORDIC arcsine (one rotation per stage).
// Reset clears all valid bits and the configuration registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; a bubble at the output lets the pipe advance again.
//
module haversine_radius_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // point_id[23:0], latitude_udeg[51:24],
                                 // longitude_udeg[80:52], zero fill
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // result_id[23:0], distance_m[48:24], zero fill
  output logic        m_tuser,   // within_radius
  output logic        m_tlast,   // end_of_set
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [28:0] cfg_wdata
);

  localparam int T_OUT = hrf_pkg::T_OUT;
  localparam int CS    = hrf_pkg::CORDIC_STAGES;
  localparam int NSQ   = hrf_pkg::FRAC + 1;

  logic adv;
  logic [T_OUT:0] vld;

  logic signed [27:0] center_lat;
  logic signed [28:0] center_lon;
  logic [24:0]        radius;

  logic signed [27:0] plat;
  logic signed [28:0] plon;

  hrf_pkg::angle_t u_reg [4];
  hrf_pkg::unit_t  s_val [4];

  logic [23:0]      id_pipe [T_OUT];
  logic [T_OUT-1:0] last_pipe;

  // Step 0: drive the global advance and the valid chain
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T_OUT-1:0], s_tvalid};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_lat <= '0;
      center_lon <= '0;
      radius     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        hrf_pkg::CFG_CENTER_LAT: center_lat <= cfg_wdata[27:0];
        hrf_pkg::CFG_CENTER_LON: center_lon <= cfg_wdata;
        hrf_pkg::CFG_RADIUS:     radius     <= cfg_wdata[24:0];
        default:                 radius     <= radius;
      endcase
    end
  end

  // Stage 0: form the four sine arguments; a micro-degree difference is a
  // half-angle in half-micro-degrees, and a quarter turn turns sine into cosine
  assign plat = s_tdata[51:24];
  assign plon = s_tdata[80:52];

  always_ff @(posedge clk) begin
    if (adv) begin
      u_reg[0]     <= 31'(center_lat) - 31'(plat);
      u_reg[1]     <= 31'(center_lon) - 31'(plon);
      u_reg[2]     <= (31'(center_lat) <<< 1) + 31'(hrf_pkg::QUARTER_TURN_U);
      u_reg[3]     <= (31'(plat) <<< 1) + 31'(hrf_pkg::QUARTER_TURN_U);
      id_pipe[0]   <= s_tdata[23:0];
      last_pipe[0] <= s_tlast;
      for (int t = 1; t < T_OUT; t++) begin
        id_pipe[t]   <= id_pipe[t-1];
        last_pipe[t] <= last_pipe[t-1];
      end
    end
  end

  // Four sine pipelines: dlat/2, dlon/2, cos(center lat), cos(point lat)
  for (genvar g = 0; g < 4; g++) begin : g_sin
    hrf_sine u_sine (
      .clk (clk),
      .en  (adv),
      .u   (u_reg[g]),
      .s   (s_val[g])
    );
  end

  // h = s1^2 + (c1 c2) s2^2, clamped to [0, 1]
  logic [61:0] ha1, ha12, ha3, ha123;
  logic        hneg1, hneg2, hneg3;
  logic [31:0] hm1r, hm12r, hm3r, hm1d;
  logic [31:0] ht;
  logic signed [32:0] hterm, hsum;
  logic [30:0] h_reg;

  always_comb begin
    ht    = hrf_pkg::rnd_q(ha123);
    hterm = hneg3 ? -$signed({1'b0, ht}) : $signed({1'b0, ht});
    hsum  = $signed({1'b0, hm1d}) + hterm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ha1   <= {31'd0, hrf_pkg::mag(s_val[0])} * {31'd0, hrf_pkg::mag(s_val[0])};
      ha12  <= {31'd0, hrf_pkg::mag(s_val[2])} * {31'd0, hrf_pkg::mag(s_val[3])};
      ha3   <= {31'd0, hrf_pkg::mag(s_val[1])} * {31'd0, hrf_pkg::mag(s_val[1])};
      hneg1 <= s_val[2][31] ^ s_val[3][31];
      hm1r  <= hrf_pkg::rnd_q(ha1);
      hm12r <= hrf_pkg::rnd_q(ha12);
      hm3r  <= hrf_pkg::rnd_q(ha3);
      hneg2 <= hneg1;
      ha123 <= {30'd0, hm12r} * {30'd0, hm3r};
      hm1d  <= hm1r;
      hneg3 <= hneg2;
      if (hsum < 0) begin
        h_reg <= '0;
      end else if (hsum > 33'(hrf_pkg::ONE)) begin
        h_reg <= hrf_pkg::ONE;
      end else begin
        h_reg <= hsum[30:0];
      end
    end
  end

  // Two digit-by-digit square roots, one result bit per stage:
  // sqrt(h) and sqrt(1 - h), each floor(sqrt(v * 2^30))
  logic [60:0] es [NSQ];
  logic [60:0] ec [NSQ];
  logic [30:0] rs [NSQ];
  logic [30:0] rcs [NSQ];

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    localparam int B = hrf_pkg::FRAC - i;
    logic [60:0] es_in, ec_in;
    logic [30:0] rs_in, rc_in;
    logic [62:0] trial_s, trial_c;

    if (i == 0) begin : g_first
      assign es_in = {h_reg, 30'd0};
      assign ec_in = {hrf_pkg::ONE - h_reg, 30'd0};
      assign rs_in = '0;
      assign rc_in = '0;
    end else begin : g_next
      assign es_in = es[i-1];
      assign ec_in = ec[i-1];
      assign rs_in = rs[i-1];
      assign rc_in = rcs[i-1];
    end

    always_comb begin
      trial_s = (63'(rs_in) << (B + 1)) + (63'd1 << (2 * B));
      trial_c = (63'(rc_in) << (B + 1)) + (63'd1 << (2 * B));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if ({2'b00, es_in} >= trial_s) begin
          es[i] <= 61'({2'b00, es_in} - trial_s);
          rs[i] <= rs_in | (31'd1 << B);
        end else begin
          es[i] <= es_in;
          rs[i] <= rs_in;
        end
        if ({2'b00, ec_in} >= trial_c) begin
          ec[i]  <= 61'({2'b00, ec_in} - trial_c);
          rcs[i] <= rc_in | (31'd1 << B);
        end else begin
          ec[i]  <= ec_in;
          rcs[i] <= rc_in;
        end
      end
    end
  end

  // CORDIC vectoring: asin(s) = atan2(s, sqrt(1 - h)), one rotation per stage
  logic signed [33:0] cx [CS];
  logic signed [33:0] cy [CS];
  logic signed [32:0] cz [CS];

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [33:0] x_in, y_in, dx, dy;
    logic signed [32:0] z_in;

    if (i == 0) begin : g_first
      assign x_in = $signed({3'd0, rcs[NSQ-1]});
      assign y_in = $signed({3'd0, rs[NSQ-1]});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = cx[i-1];
      assign y_in = cy[i-1];
      assign z_in = cz[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_in[33]) begin
          cx[i] <= x_in + dx;
          cy[i] <= y_in - dy;
          cz[i] <= z_in + $signed({2'b00, hrf_pkg::atan_q(i)});
        end else begin
          cx[i] <= x_in - dx;
          cy[i] <= y_in + dy;
          cz[i] <= z_in - $signed({2'b00, hrf_pkg::atan_q(i)});
        end
      end
    end
  end

  // Clamp the angle to [0, pi/2], scale by the diameter, round and saturate
  logic [30:0] zc;
  logic [54:0] dprod;
  logic [55:0] dsum;
  logic [24:0] dist_m;

  always_comb begin
    if (cz[CS-1] < 0) begin
      zc = '0;
    end else if (cz[CS-1] > $signed({2'b00, hrf_pkg::HALF_PI})) begin
      zc = hrf_pkg::HALF_PI;
    end else begin
      zc = cz[CS-1][30:0];
    end
    dsum   = {1'b0, dprod} + (56'd1 << (hrf_pkg::FRAC - 1));
    dist_m = (dsum[55:30] > 26'(hrf_pkg::DIST_MAX)) ? hrf_pkg::DIST_MAX : dsum[54:30];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dprod   <= {24'd0, zc} * {31'd0, hrf_pkg::DIAMETER_M};
      m_tdata <= {7'd0, dist_m, id_pipe[T_OUT-1]};
      m_tuser <= (dist_m <= radius);
      m_tlast <= last_pipe[T_OUT-1];
    end
  end

`ifndef SYNTH
  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:24] <= hrf_pkg::DIST_MAX))
    else $error("distance above saturation limit");

  a_within: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[48:24] <= radius)))
    else $error("within flag disagrees with distance");

  a_h_range: assert property (@(posedge clk) disable iff (rst)
    vld[hrf_pkg::T_H] |-> (h_reg <= hrf_pkg::ONE))
    else $error("haversine term out of range");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    vld[hrf_pkg::T_SIN] |-> ((s_val[0] <= $signed(32'(hrf_pkg::ONE))) &&
                             (s_val[0] >= -$signed(32'(hrf_pkg::ONE)))))
    else $error("sine magnitude above one");
`endif

endmodule

/* hw/rtl/hrf_sine.sv */
// ============================================================================
// hrf_sine - pipelined fixed-point sine of an angle in half-micro-degrees
// Quadrant fold, radian scaling, Horner Taylor series with one level per
// three stages, final scaling and sign. Advances when en is high.
// ============================================================================
module hrf_sine (
  input  logic            clk,
  input  logic            en,
  input  hrf_pkg::angle_t u,
  output hrf_pkg::unit_t  s
);

  localparam int TT = hrf_pkg::TAYLOR_TERMS;

  logic signed [31:0] wrap;
  logic signed [31:0] fold;
  logic signed [31:0] fold2;
  logic               red_neg;

  logic [27:0] m1;
  logic        n1;
  logic [63:0] mp2;
  logic        n2;
  logic [30:0] th3;
  logic        n3;
  logic [61:0] thsq4;
  logic [30:0] th4;
  logic        n4;
  logic [31:0] t2_5;
  logic [30:0] th5;
  logic        n5;

  logic [63:0] sum3;
  logic [62:0] sum5;

  logic [62:0] pa  [TT];
  logic [31:0] t2a [TT];
  logic [30:0] tha [TT];
  logic        na  [TT];
  logic [31:0] xb  [TT];
  logic [61:0] pmb [TT];
  logic [31:0] t2b [TT];
  logic [30:0] thb [TT];
  logic        nb  [TT];
  logic [30:0] rc  [TT];
  logic [31:0] t2c [TT];
  logic [30:0] thc [TT];
  logic        nc  [TT];

  logic [61:0] rp;
  logic        nf;
  logic [62:0] rsum;
  logic [31:0] rr;
  hrf_pkg::unit_t rs;

  // Fold into the first quadrant
  always_comb begin
    wrap    = (u < 0) ? (32'(u) + 32'(hrf_pkg::FULL_TURN_U)) : 32'(u);
    red_neg = (wrap >= 32'(hrf_pkg::HALF_TURN_U));
    fold    = red_neg ? (wrap - 32'(hrf_pkg::HALF_TURN_U)) : wrap;
    fold2   = (fold > 32'(hrf_pkg::QUARTER_TURN_U)) ?
              (32'(hrf_pkg::HALF_TURN_U) - fold) : fold;
    sum3    = mp2 + (64'd1 << 31);
    sum5    = {1'b0, thsq4} + (63'd1 << (hrf_pkg::FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= fold2[27:0];
      n1    <= red_neg;
      mp2   <= {36'd0, m1} * {28'd0, hrf_pkg::RAD_PER_U};
      n2    <= n1;
      th3   <= sum3[62:32];
      n3    <= n2;
      thsq4 <= {31'd0, th3} * {31'd0, th3};
      th4   <= th3;
      n4    <= n3;
      t2_5  <= sum5[61:30];
      th5   <= th4;
      n5    <= n4;
    end
  end

  for (genvar j = 0; j < TT; j++) begin : g_lvl
    localparam int    K  = TT - j;
    localparam int    D  = 2 * K * (2 * K + 1);
    localparam longint MR = 64'sd4294967296 / D;

    logic [31:0] t2_in;
    logic [30:0] r_in;
    logic [30:0] th_in;
    logic        n_in;
    logic [62:0] xs;
    logic [29:0] q0;
    logic [32:0] rem;
    logic [30:0] q;

    if (j == 0) begin : g_first
      assign t2_in = t2_5;
      assign r_in  = hrf_pkg::ONE;
      assign th_in = th5;
      assign n_in  = n5;
    end else begin : g_next
      assign t2_in = t2c[j-1];
      assign r_in  = rc[j-1];
      assign th_in = thc[j-1];
      assign n_in  = nc[j-1];
    end

    // Divide by the constant through its reciprocal, then correct by one
    always_comb begin
      xs  = pa[j] + (63'd1 << (hrf_pkg::FRAC - 1));
      q0  = pmb[j][61:32];
      rem = {1'b0, xb[j]} - (33'(q0) * 33'(D));
      q   = (rem >= 33'(D)) ? (31'(q0) + 31'd1) : 31'(q0);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa[j]  <= {31'd0, t2_in} * {32'd0, r_in};
        t2a[j] <= t2_in;
        tha[j] <= th_in;
        na[j]  <= n_in;
        xb[j]  <= xs[61:30];
        pmb[j] <= {30'd0, xs[61:30]} * {32'd0, 30'(MR)};
        t2b[j] <= t2a[j];
        thb[j] <= tha[j];
        nb[j]  <= na[j];
        rc[j]  <= hrf_pkg::ONE - q;
        t2c[j] <= t2b[j];
        thc[j] <= thb[j];
        nc[j]  <= nb[j];
      end
    end
  end

  always_comb begin
    rsum = {1'b0, rp} + (63'd1 << (hrf_pkg::FRAC - 1));
    rr   = rsum[61:30];
    if (rr > 32'(hrf_pkg::ONE)) begin
      rr = 32'(hrf_pkg::ONE);
    end
    rs = nf ? -hrf_pkg::unit_t'(rr) : hrf_pkg::unit_t'(rr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp <= {31'd0, thc[TT-1]} * {31'd0, rc[TT-1]};
      nf <= nc[TT-1];
      s  <= rs;
    end
  end

endmodule

/* tb/haversine_radius_filter_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haversine_radius_filter_checker - distance predictor and result scoreboard
// Tracks the centre and radius registers, computes the fixed-point haversine
// distance of every accepted point and checks each result against it, in order.
// ----------------------------------------------------------------------------
module haversine_radius_filter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [28:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  localparam int FRAC           = hrf_pkg::FRAC;
  localparam int CORDIC_STAGES  = hrf_pkg::CORDIC_STAGES;
  localparam int TAYLOR_TERMS   = hrf_pkg::TAYLOR_TERMS;
  localparam int FULL_TURN_U    = hrf_pkg::FULL_TURN_U;
  localparam int HALF_TURN_U    = hrf_pkg::HALF_TURN_U;
  localparam int QUARTER_TURN_U = hrf_pkg::QUARTER_TURN_U;

  typedef struct packed {
    logic [23:0] id;
    logic        in_radius;
    logic [24:0] distance;
    logic        eos;
  } dist_result_t;

  dist_result_t       dist_expected[$];
  longint             ctr_lat, ctr_lon;
  longint unsigned    radius;
  longint unsigned    atan_tab[CORDIC_STAGES];
  longint             halfpi_v;
  longint unsigned    rad_u62;

  function automatic longint unsigned atan_recip(longint unsigned m);
    longint unsigned p, m2, acc, t;
    p = (64'd1 << 62) / m;
    m2 = m * m;
    acc = 0;
    for (int k = 0; k < 64 && p != 0; k++) begin
      t = p / (2 * k + 1);
      if (k % 2) acc = acc - t;
      else acc = acc + t;
      p = p / m2;
    end
    return acc;
  endfunction

  function automatic longint q62_round(longint unsigned v);
    return longint'((v + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
  endfunction

  // signed QF product, rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    logic [127:0]    p;
    longint unsigned ua, ub;
    longint          r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (FRAC - 1));
    r = longint'(p[FRAC +: 64]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // sine of an angle in half-micro-degrees
  function automatic longint sine_half_udeg(longint u);
    longint full, m, th, t2, r;
    logic   neg;
    full = FULL_TURN_U;
    m = ((u % full) + full) % full;
    neg = 0;
    if (m >= HALF_TURN_U) begin
      neg = 1;
      m = m - HALF_TURN_U;
    end
    if (m > QUARTER_TURN_U) m = HALF_TURN_U - m;
    th = longint'((longint'(m) * rad_u62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
    t2 = qmul(th, th);
    r = longint'(1) << FRAC;
    for (int k = TAYLOR_TERMS; k >= 1; k--)
      r = (longint'(1) << FRAC) - qmul(t2, r) / longint'((2 * k) * (2 * k + 1));
    r = qmul(th, r);
    if (r < 0) r = 0;
    if (r > (longint'(1) << FRAC)) r = longint'(1) << FRAC;
    return neg ? -r : r;
  endfunction

  function automatic longint sqrt_floor(longint v);
    logic [127:0] n, c;
    longint       r;
    n = {64'd0, v} << FRAC;
    r = 0;
    for (int b = FRAC; b >= 0; b--) begin
      c = {64'd0, r | (longint'(1) << b)};
      if (c * c <= n) r = r | (longint'(1) << b);
    end
    return r;
  endfunction

  function automatic longint unsigned great_circle_m(longint plat, longint plon);
    longint       s1, s2, c1, c2, h, x, y, z, dx, dy;
    logic [127:0] p;
    longint unsigned d;
    s1 = sine_half_udeg(ctr_lat - plat);
    s2 = sine_half_udeg(ctr_lon - plon);
    c1 = sine_half_udeg(2 * ctr_lat + QUARTER_TURN_U);
    c2 = sine_half_udeg(2 * plat + QUARTER_TURN_U);
    h = qmul(s1, s1) + qmul(qmul(c1, c2), qmul(s2, s2));
    if (h < 0) h = 0;
    if (h > (longint'(1) << FRAC)) h = longint'(1) << FRAC;
    x = sqrt_floor((longint'(1) << FRAC) - h);
    y = sqrt_floor(h);
    z = 0;
    // vectoring CORDIC: angle of (sqrt(1-h), sqrt(h)) is asin(sqrt(h))
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_tab[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_tab[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > halfpi_v) z = halfpi_v;
    p = {64'd0, z} * 128'd12742000 + (128'd1 << (FRAC - 1));
    d = p[FRAC +: 64];
    if (d > 20015087) d = 20015087;
    return d;
  endfunction

  initial begin
    longint unsigned a1;
    a1 = atan_recip(2) + atan_recip(3);
    rad_u62 = (a1 * 4 + 64'd180000000) / 64'd360000000;
    halfpi_v = q62_round(a1 * 2);
    for (int i = 0; i < CORDIC_STAGES; i++)
      atan_tab[i] = q62_round(i == 0 ? a1 : atan_recip(64'd1 << i));
  end

  assign pending = dist_expected.size();

  always @(posedge clk) begin
    dist_result_t    e, got;
    longint unsigned d;
    if (rst) begin
      ctr_lat <= 0;
      ctr_lon <= 0;
      radius  <= 0;
      errors  <= 0;
      dist_expected.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          hrf_pkg::CFG_CENTER_LAT: ctr_lat <= longint'($signed(cfg_wdata[27:0]));
          hrf_pkg::CFG_CENTER_LON: ctr_lon <= longint'($signed(cfg_wdata[28:0]));
          hrf_pkg::CFG_RADIUS:     radius  <= cfg_wdata[24:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        d = great_circle_m(longint'($signed(s_tdata[51:24])),
                           longint'($signed(s_tdata[80:52])));
        e.id        = s_tdata[23:0];
        e.distance  = d[24:0];
        e.in_radius = (d <= radius);
        e.eos       = s_tlast;
        dist_expected = {dist_expected, e};
      end
      if (m_tvalid && m_tready) begin
        got.id        = m_tdata[23:0];
        got.distance  = m_tdata[48:24];
        got.in_radius = m_tuser;
        got.eos       = m_tlast;
        if (dist_expected.size() == 0) begin
          $display("%0t: result with none expected: id %0d dist %0d", $time,
                   got.id, got.distance);
          errors <= errors + 1;
        end else begin
          e = dist_expected.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected id %0d dist %0d within %0b last %0b,",
                     $time, e.id, e.distance, e.in_radius, e.eos);
            $display("%0t:          actual   id %0d dist %0d within %0b last %0b",
                     $time, got.id, got.distance, got.in_radius, got.eos);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_haversine_radius_filter_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haversine_radius_filter_core - stimulus and verdict for the radius filter
// Streams directed and random points under several centre/radius settings,
// with random stalls on both sides; a checker module scores every result.
// ----------------------------------------------------------------------------
module tb_haversine_radius_filter_core;

  // index outside the register list, written to check that it is ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [87:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser, m_tlast;
  logic [55:0] m_tdata;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [28:0] cfg_wdata;
  int          errors, pending;

  // shared between the stimulus and the receiver process (the centre copies: stimulus only)
  logic        idle_on   = 1;
  logic        long_hold = 0;
  int          ctr_lat_v = 0;
  int          ctr_lon_v = 0;

  haversine_radius_filter_core uut (.*);

  haversine_radius_filter_checker chk (.*);

  always begin
    clk = 1; #1;
    clk = 0; #1;
  end

  // Limit: far beyond the slowest correct run
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random backpressure bursts, plus one long hold on request
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Offer one point and hold it until the request is taken
  task automatic send_point(input logic [23:0] id, input int lat, input int lon,
                            input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tdata  <= {7'd0, lon[28:0], lat[27:0], id};
    s_tlast  <= last;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every result is back, then let the pipe drain
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val[28:0];
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_region(input int lat, input int lon, input int rad);
    write_reg(hrf_pkg::CFG_CENTER_LAT, lat);
    write_reg(hrf_pkg::CFG_CENTER_LON, lon);
    write_reg(hrf_pkg::CFG_RADIUS, rad);
    ctr_lat_v = lat;
    ctr_lon_v = lon;
  endtask

  // Mostly points around the centre so the radius test flips, some anywhere,
  // a few with raw full-width coordinates (latitude wrap)
  task automatic random_points(input int n);
    int sel, off, lat, lon;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) begin
        off = (sel < 4) ? $urandom_range(0, 20000) : $urandom_range(0, 3000000);
        lat = ctr_lat_v + $urandom_range(0, 2 * off) - off;
        lon = ctr_lon_v + $urandom_range(0, 2 * off) - off;
      end else if (sel < 18) begin
        lat = $urandom_range(0, 180000000) - 90000000;
        lon = $urandom_range(0, 360000000) - 180000000;
      end else begin
        lat = $signed($urandom_range(0, 32'h0FFFFFFF) << 4) >>> 4;
        lon = $signed($urandom_range(0, 32'h1FFFFFFF) << 3) >>> 3;
      end
      send_point(24'($urandom()), lat, lon, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    rst       = 1;
    s_tvalid  = 0;
    s_tdata   = '0;
    s_tlast   = 0;
    cfg_wr_en = 0;
    cfg_addr  = hrf_pkg::CFG_CENTER_LAT;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: reset config (centre at origin, zero radius)
    send_point(24'd0, 0, 0, 0);                       // zero distance, inside
    send_point(24'hFFFFFF, 90000000, 0, 0);           // pole
    send_point(24'd1, -90000000, 180000000, 0);
    send_point(24'd2, 0, 180000000, 0);               // antipode, saturates
    send_point(24'd3, 0, -180000000, 1);
    send_point(24'd4, -134217728, -268435456, 0);     // field minimums, wrap
    send_point(24'd5, 134217727, 268435455, 0);       // field maximums
    send_point(24'd6, 100000000, 10, 1);              // beyond the pole
    drain();

    // Extreme centre, full-range radius values, ignored index
    set_region(90000000, 180000000, 20015087);
    write_reg(CFG_UNUSED, 29'h1FFFFFFF);
    send_point(24'd7, -90000000, -180000000, 0);
    send_point(24'd8, 90000000, 180000000, 0);
    send_point(24'd9, 0, 0, 1);
    drain();
    set_region(-90000000, -180000000, 33554431);
    send_point(24'd10, 90000000, 0, 0);
    send_point(24'd11, -90000000, -180000000, 0);
    send_point(24'd12, -89999999, 179999999, 1);
    drain();

    // Radius boundary: exact centre, distance 0 against radius 0
    set_region(45000000, -73000000, 0);
    send_point(24'd13, 45000000, -73000000, 0);
    send_point(24'd14, 45000001, -73000000, 1);
    drain();

    // Random phases under several settings
    for (int ph = 0; ph < 4; ph++) begin
      set_region($urandom_range(0, 180000000) - 90000000,
                 $urandom_range(0, 360000000) - 180000000,
                 (ph == 3) ? $urandom_range(0, 33554431) : $urandom_range(0, 300000));
      if (ph == 1) begin
        // receiver stalls long while more points are offered than the pipe holds
        long_hold = 1;
        random_points(110);
      end else begin
        random_points(100);
      end
      drain();                // sender pauses until every result is back
    end

    // Final part: no idling on either side
    set_region(51500000, -120000, 150000);
    idle_on = 0;
    random_points(60);
    drain();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hrf_pkg.sv
hw/rtl/hrf_sine.sv
hw/rtl/haversine_radius_filter_core.sv
tb/haversine_radius_filter_checker.sv
tb/tb_haversine_radius_filter_core.sv
